[src/swp_pkg.sv]
// ----------------------------------------------------------------------------
// swp_pkg
// Shared types and constants for the section window profiler.
// ----------------------------------------------------------------------------
package swp_pkg;

    localparam int SECTIONS     = 16;
    localparam int WINDOW_DEPTH = 64;
    localparam int SEC_W        = $clog2(SECTIONS);
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int RING_AW      = SEC_W + PTR_W;
    localparam int SUM_W        = 38;

    localparam logic [31:0] US_PER_SECOND = 32'd1000000;
    localparam logic [31:0] FPS_SCALE     = 32'd256000000;
    localparam logic [6:0]  WINDOW_RESET  = 7'd60;

    localparam logic [2:0] FN_BEGIN_SEC = 3'd0;
    localparam logic [2:0] FN_END_SEC   = 3'd1;
    localparam logic [2:0] FN_BEGIN_FRM = 3'd2;
    localparam logic [2:0] FN_END_FRM   = 3'd3;
    localparam logic [2:0] FN_QUERY     = 3'd4;
    localparam logic [2:0] FN_CLR_SEC   = 3'd5;
    localparam logic [2:0] FN_CLR_ALL   = 3'd6;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_NO_BEGIN = 2'd2;

    localparam logic [0:0] REG_ENABLED = 1'd0;
    localparam logic [0:0] REG_WINDOW  = 1'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  section_id;
        logic [31:0] timestamp_us;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] last_duration;
        logic [37:0] window_sum;
        logic [6:0]  sample_count;
        logic [31:0] average_us;
        logic [31:0] min_duration;
        logic [31:0] max_duration;
        logic [31:0] frame_time_us;
        logic [31:0] fps_q8;
    } out_word_t;

    // per-section record kept in the section memory
    typedef struct packed {
        logic [31:0]      open_start;
        logic             open_valid;
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] total;
        logic [31:0]      least;
        logic [31:0]      most;
    } sec_rec_t;

    localparam sec_rec_t SEC_CLEAR = '{
        open_start: '0, open_valid: 1'b0, head: '0, count: '0,
        total: '0, least: '1, most: '0};

endpackage

[src/swp_divider.sv]
// ----------------------------------------------------------------------------
// swp_divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module swp_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quot_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [6:0]  bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial    = {rem_reg[31:0], quot_reg[63]};
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quot_reg <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                bit_reg  <= 7'd64;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_reg  <= trial - {1'b0, dsr_reg};
                    quot_reg <= {quot_reg[62:0], 1'b1};
                end else begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[62:0], 1'b0};
                end
                bit_reg <= bit_reg - 7'd1;
                if (bit_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[src/section_window_profiler.sv]
// an accepted word passes S_READ, S_WRITE, S_LAST_RD, S_LAST and the 64-step average divide in S_AVG
// end-section adds an S_TRIM_RD, S_TRIM pass per trimmed entry, frame end with fps adds a divide in S_FPS
// clear-all walks the 16 section records in S_WRITE, one per cycle
// throughput: one word at a time; the next word is taken the cycle after the result is held
// synchronous active-low reset: counters cleared, enabled 0, window length 60;
// section memory is swept clear in S_CLEAR after reset before any word is taken
// ----------------------------------------------------------------------------
// section_window_profiler
// Per-section duration windows with min/max, plus frame time and fps.
// ----------------------------------------------------------------------------
module section_window_profiler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  swp_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output swp_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_TRIM_RD, S_TRIM, S_WRITE, S_LAST_RD, S_LAST,
        S_AVG, S_FPS, S_OUT
    } state_t;

    state_t state_reg;

    logic       enabled_reg;
    logic [6:0] window_reg;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            window_reg  <= swp_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                swp_pkg::REG_ENABLED: enabled_reg <= pwdata[0];
                swp_pkg::REG_WINDOW:  window_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[2])
            swp_pkg::REG_ENABLED: prdata = {31'd0, enabled_reg};
            swp_pkg::REG_WINDOW:  prdata = {25'd0, window_reg};
            default:              prdata = '0;
        endcase
    end

    logic [swp_pkg::CNT_W-1:0] win_eff;
    always_comb begin
        if (window_reg == 7'd0)
            win_eff = swp_pkg::CNT_W'(1);
        else if (window_reg > 7'(swp_pkg::WINDOW_DEPTH))
            win_eff = swp_pkg::CNT_W'(swp_pkg::WINDOW_DEPTH);
        else
            win_eff = window_reg[swp_pkg::CNT_W-1:0];
    end

    swp_pkg::in_word_t         in_reg;
    swp_pkg::sec_rec_t         rec_reg;
    swp_pkg::sec_rec_t         rec_push;
    logic [31:0]               rec_new_reg;
    logic [1:0]                status_reg;
    logic [swp_pkg::SEC_W-1:0] idx_reg;
    logic [31:0]               last_reg;
    logic [31:0]               avg_reg;
    logic [31:0]               frame_begin_reg;
    logic                      frame_begun_reg;
    logic [31:0]               frame_time_reg;
    logic [31:0]               frames_reg;
    logic [31:0]               interval_reg;
    logic [31:0]               fps_reg;
    logic [31:0]               elapsed_reg;
    swp_pkg::out_word_t        out_reg;
    logic                      m_valid_reg;

    // memories
    swp_pkg::sec_rec_t sec_mem [swp_pkg::SECTIONS];
    logic [31:0]       ring_mem [swp_pkg::SECTIONS * swp_pkg::WINDOW_DEPTH];
    swp_pkg::sec_rec_t sec_rd_reg;
    logic [31:0]       ring_rd_reg;
    logic                      sec_we;
    logic [swp_pkg::SEC_W-1:0] sec_addr;
    swp_pkg::sec_rec_t         sec_wdata;
    logic                      ring_we;
    logic [swp_pkg::RING_AW-1:0] ring_addr;

    always_ff @(posedge aclk) begin
        if (sec_we) sec_mem[sec_addr] <= sec_wdata;
        sec_rd_reg <= sec_mem[sec_addr];
    end
    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[ring_addr] <= rec_new_reg;
        ring_rd_reg <= ring_mem[ring_addr];
    end

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_q;

    swp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    logic [swp_pkg::SEC_W-1:0] sec_id;
    assign sec_id = s_data.section_id[swp_pkg::SEC_W-1:0];

    logic [swp_pkg::PTR_W-1:0] tail_ptr;
    logic [swp_pkg::PTR_W-1:0] newest_ptr;
    assign tail_ptr   = rec_reg.head + rec_reg.count[swp_pkg::PTR_W-1:0];
    assign newest_ptr = tail_ptr - swp_pkg::PTR_W'(1);

    // record after the new duration is pushed
    always_comb begin
        rec_push       = rec_reg;
        rec_push.count = rec_reg.count + swp_pkg::CNT_W'(1);
        rec_push.total = rec_reg.total + swp_pkg::SUM_W'(rec_new_reg);
        if (rec_new_reg < rec_reg.least) rec_push.least = rec_new_reg;
        if (rec_new_reg > rec_reg.most) rec_push.most = rec_new_reg;
    end

    always_comb begin
        sec_we       = 1'b0;
        sec_addr     = idx_reg;
        sec_wdata    = rec_reg;
        ring_we      = 1'b0;
        ring_addr    = {idx_reg, rec_reg.head};
        div_start    = 1'b0;
        div_dividend = 64'(rec_reg.total);
        div_divisor  = 32'(rec_reg.count);
        unique case (state_reg)
            S_CLEAR: begin
                sec_we    = 1'b1;
                sec_wdata = swp_pkg::SEC_CLEAR;
            end
            S_IDLE: sec_addr = sec_id;
            S_WRITE: begin
                sec_we = 1'b1;
                ring_we = (in_reg.func == swp_pkg::FN_END_SEC) && (status_reg == swp_pkg::ST_DONE);
                ring_addr = {idx_reg, tail_ptr};
                if (ring_we) sec_wdata = rec_push;
            end
            S_LAST_RD: ring_addr = {idx_reg, newest_ptr};
            S_LAST: div_start = 1'b1;
            S_AVG: begin
                div_start    = div_done && (in_reg.func == swp_pkg::FN_END_FRM)
                               && enabled_reg && (elapsed_reg >= swp_pkg::US_PER_SECOND);
                div_dividend = 64'(frames_reg + 32'd1) * 64'(swp_pkg::FPS_SCALE);
                div_divisor  = elapsed_reg;
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            idx_reg         <= '0;
            m_valid_reg     <= 1'b0;
            frame_begin_reg <= '0;
            frame_begun_reg <= 1'b0;
            frame_time_reg  <= '0;
            frames_reg      <= '0;
            interval_reg    <= '0;
            fps_reg         <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + swp_pkg::SEC_W'(1);
                    if (idx_reg == swp_pkg::SEC_W'(swp_pkg::SECTIONS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        idx_reg   <= sec_id;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    rec_reg    <= sec_rd_reg;
                    status_reg <= swp_pkg::ST_DONE;
                    elapsed_reg <= in_reg.timestamp_us - interval_reg;
                    rec_new_reg <= in_reg.timestamp_us - sec_rd_reg.open_start;
                    state_reg  <= S_WRITE;
                    case (in_reg.func)
                        swp_pkg::FN_BEGIN_SEC: begin
                            if (!enabled_reg) status_reg <= swp_pkg::ST_DISABLED;
                            else begin
                                rec_reg.open_start <= in_reg.timestamp_us;
                                rec_reg.open_valid <= 1'b1;
                            end
                        end
                        swp_pkg::FN_END_SEC: begin
                            if (!enabled_reg) status_reg <= swp_pkg::ST_DISABLED;
                            else if (!sec_rd_reg.open_valid)
                                status_reg <= swp_pkg::ST_NO_BEGIN;
                            else begin
                                rec_reg.open_valid <= 1'b0;
                                if (sec_rd_reg.count >= win_eff) state_reg <= S_TRIM_RD;
                            end
                        end
                        swp_pkg::FN_BEGIN_FRM: begin
                            if (!enabled_reg) status_reg <= swp_pkg::ST_DISABLED;
                            else begin
                                frame_begin_reg <= in_reg.timestamp_us;
                                frame_begun_reg <= 1'b1;
                            end
                        end
                        swp_pkg::FN_END_FRM: begin
                            if (!enabled_reg) status_reg <= swp_pkg::ST_DISABLED;
                            else if (frame_begun_reg)
                                frame_time_reg <= in_reg.timestamp_us - frame_begin_reg;
                        end
                        swp_pkg::FN_CLR_SEC: rec_reg <= swp_pkg::SEC_CLEAR;
                        swp_pkg::FN_CLR_ALL: begin
                            rec_reg        <= swp_pkg::SEC_CLEAR;
                            idx_reg        <= '0;
                            frame_time_reg <= '0;
                            fps_reg        <= '0;
                            frames_reg     <= '0;
                            interval_reg   <= in_reg.timestamp_us;
                        end
                        default: ;
                    endcase
                end
                // ring address already points at the oldest entry
                S_TRIM_RD: state_reg <= S_TRIM;
                S_TRIM: begin
                    rec_reg.total <= rec_reg.total - swp_pkg::SUM_W'(ring_rd_reg);
                    rec_reg.head  <= rec_reg.head + swp_pkg::PTR_W'(1);
                    rec_reg.count <= rec_reg.count - swp_pkg::CNT_W'(1);
                    if (rec_reg.count - swp_pkg::CNT_W'(1) >= win_eff) state_reg <= S_TRIM_RD;
                    else state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    if (ring_we) rec_reg <= rec_push;
                    if (in_reg.func == swp_pkg::FN_CLR_ALL
                            && idx_reg != swp_pkg::SEC_W'(swp_pkg::SECTIONS - 1)) begin
                        // walk every record, then return to the addressed one
                        idx_reg <= idx_reg + swp_pkg::SEC_W'(1);
                        state_reg <= S_WRITE;
                    end else begin
                        state_reg <= S_LAST_RD;
                    end
                    if (in_reg.func == swp_pkg::FN_CLR_ALL
                            && idx_reg == swp_pkg::SEC_W'(swp_pkg::SECTIONS - 1))
                        idx_reg <= in_reg.section_id[swp_pkg::SEC_W-1:0];
                end
                S_LAST_RD: state_reg <= S_LAST;
                S_LAST: begin
                    last_reg  <= ring_rd_reg;
                    state_reg <= S_AVG;
                end
                S_AVG: begin
                    if (div_done) begin
                        avg_reg <= (rec_reg.count == '0) ? 32'd0 : div_q[31:0];
                        if (in_reg.func == swp_pkg::FN_END_FRM && enabled_reg) begin
                            if (elapsed_reg >= swp_pkg::US_PER_SECOND) begin
                                state_reg <= S_FPS;
                            end else begin
                                frames_reg <= frames_reg + 32'd1;
                                state_reg  <= S_OUT;
                            end
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_FPS: begin
                    if (div_done) begin
                        fps_reg      <= (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                        frames_reg   <= '0;
                        interval_reg <= in_reg.timestamp_us;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.status        <= status_reg;
                        out_reg.last_duration <= (rec_reg.count == '0) ? 32'd0 : last_reg;
                        out_reg.window_sum    <= rec_reg.total;
                        out_reg.sample_count  <= 7'(rec_reg.count);
                        out_reg.average_us    <= avg_reg;
                        out_reg.min_duration  <= (rec_reg.count == '0) ? 32'd0 : rec_reg.least;
                        out_reg.max_duration  <= (rec_reg.count == '0) ? 32'd0 : rec_reg.most;
                        out_reg.frame_time_us <= frame_time_reg;
                        out_reg.fps_q8        <= fps_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed while stalled");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (rec_reg.count <= swp_pkg::CNT_W'(swp_pkg::WINDOW_DEPTH)))
        else $error("window overfull");
`endif

endmodule

[tb/section_window_profiler_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_window_profiler_checker
// Watches both channels and the register port, keeps its own model of the
// section windows and frame counters, and compares every result word.
// ----------------------------------------------------------------------------
module section_window_profiler_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  swp_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  swp_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending_words,
    output int                 checked_words
);
    import swp_pkg::*;

    logic [31:0] open_start [SECTIONS];
    logic        open_valid [SECTIONS];
    logic [31:0] durations  [SECTIONS][WINDOW_DEPTH];
    logic [5:0]  head       [SECTIONS];
    logic [6:0]  count      [SECTIONS];
    logic [37:0] total      [SECTIONS];
    logic [31:0] least      [SECTIONS];
    logic [31:0] most       [SECTIONS];
    logic [31:0] frame_mark, frame_time, frame_tally, rate_start, fps;
    logic        frame_open;
    logic        en;
    logic [6:0]  win_len;
    out_word_t   expected_words [$];

    function automatic void clear_section(int s);
        open_start[s] = 0; open_valid[s] = 0; head[s] = 0; count[s] = 0;
        total[s] = 0; least[s] = '1; most[s] = 0;
    endfunction

    function automatic void push_duration(int s, logic [31:0] d);
        int w;
        w = (win_len == 0) ? 1 : (win_len > WINDOW_DEPTH ? WINDOW_DEPTH : win_len);
        while (count[s] >= w) begin
            total[s] = total[s] - durations[s][head[s]];
            head[s] = head[s] + 1;
            count[s] = count[s] - 1;
        end
        durations[s][6'(head[s] + count[s])] = d;
        count[s] = count[s] + 1;
        total[s] = total[s] + d;
        if (d < least[s]) least[s] = d;
        if (d > most[s]) most[s] = d;
    endfunction

    function automatic out_word_t profile_event(in_word_t w);
        out_word_t   r;
        int          s;
        logic [31:0] ts, elapsed;
        logic [63:0] q;
        s = w.section_id;
        ts = w.timestamp_us;
        r = '0;
        r.status = ST_DONE;
        case (w.func)
            FN_BEGIN_SEC: begin
                if (!en) r.status = ST_DISABLED;
                else begin
                    open_start[s] = ts; open_valid[s] = 1;
                end
            end
            FN_END_SEC: begin
                if (!en) r.status = ST_DISABLED;
                else if (!open_valid[s]) r.status = ST_NO_BEGIN;
                else begin
                    open_valid[s] = 0;
                    push_duration(s, ts - open_start[s]);
                end
            end
            FN_BEGIN_FRM: begin
                if (!en) r.status = ST_DISABLED;
                else begin
                    frame_mark = ts; frame_open = 1;
                end
            end
            FN_END_FRM: begin
                if (!en) r.status = ST_DISABLED;
                else begin
                    if (frame_open) frame_time = ts - frame_mark;
                    frame_tally = frame_tally + 1;
                    elapsed = ts - rate_start;
                    if (elapsed >= US_PER_SECOND) begin
                        q = (64'(frame_tally) * 64'(FPS_SCALE)) / 64'(elapsed);
                        fps = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                        frame_tally = 0;
                        rate_start = ts;
                    end
                end
            end
            FN_CLR_SEC: clear_section(s);
            FN_CLR_ALL: begin
                for (int k = 0; k < SECTIONS; k++) clear_section(k);
                frame_time = 0; fps = 0; frame_tally = 0; rate_start = ts;
            end
            default: ;
        endcase
        r.sample_count = count[s];
        r.window_sum = total[s];
        if (count[s] != 0) begin
            r.last_duration = durations[s][6'(head[s] + count[s] - 1)];
            r.average_us = 32'(total[s] / count[s]);
            r.min_duration = least[s];
            r.max_duration = most[s];
        end
        r.frame_time_us = frame_time;
        r.fps_q8 = fps;
        return r;
    endfunction

    assign pending_words = expected_words.size();

    always @(posedge aclk) begin
        out_word_t e;
        if (!aresetn) begin
            for (int k = 0; k < SECTIONS; k++) clear_section(k);
            frame_mark = 0; frame_open = 0; frame_time = 0; frame_tally = 0;
            rate_start = 0; fps = 0; en = 0; win_len = WINDOW_RESET;
            expected_words.delete();
            fail_count <= 0;
            checked_words <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_ENABLED) en = pwdata[0];
                else win_len = pwdata[6:0];
            end
            if (s_valid && s_ready) expected_words.push_back(profile_event(s_data));
            if (m_valid && m_ready) begin
                checked_words <= checked_words + 1;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (e != m_data) begin
                        fail_count <= fail_count + 1;
                        if (e.status != m_data.status)
                            $error("status exp %0d got %0d", e.status, m_data.status);
                        if (e.last_duration != m_data.last_duration)
                            $error("last_duration exp %0d got %0d",
                                   e.last_duration, m_data.last_duration);
                        if (e.window_sum != m_data.window_sum)
                            $error("window_sum exp %0d got %0d",
                                   e.window_sum, m_data.window_sum);
                        if (e.sample_count != m_data.sample_count)
                            $error("sample_count exp %0d got %0d",
                                   e.sample_count, m_data.sample_count);
                        if (e.average_us != m_data.average_us)
                            $error("average_us exp %0d got %0d",
                                   e.average_us, m_data.average_us);
                        if (e.min_duration != m_data.min_duration)
                            $error("min_duration exp %0d got %0d",
                                   e.min_duration, m_data.min_duration);
                        if (e.max_duration != m_data.max_duration)
                            $error("max_duration exp %0d got %0d",
                                   e.max_duration, m_data.max_duration);
                        if (e.frame_time_us != m_data.frame_time_us)
                            $error("frame_time_us exp %0d got %0d",
                                   e.frame_time_us, m_data.frame_time_us);
                        if (e.fps_q8 != m_data.fps_q8)
                            $error("fps_q8 exp %0d got %0d", e.fps_q8, m_data.fps_q8);
                    end
                end
            end
        end
    end

endmodule

[tb/section_window_profiler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_window_profiler_tb
// Drives directed and random profiling events through the profiler under
// several register settings, with random gaps and a long output stall.
// ----------------------------------------------------------------------------
module section_window_profiler_tb;
    import swp_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_word_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_word_t          m_data;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count, pending_words, checked_words;
    logic [31:0]        clock_us;
    int                 sent_words;
    int                 big_stall;

    section_window_profiler dut (.*);

    section_window_profiler_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending_words, .checked_words);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // valid stays high between words when no gap is drawn
    task automatic send_event(input logic [2:0] fn, input logic [3:0] sec,
                              input logic [31:0] ts);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{func: fn, section_id: sec, timestamp_us: ts};
        do @(posedge aclk); while (!s_ready);
        sent_words++;
    endtask

    // wait for all results, then let the profiler idle before the next phase
    task automatic drain();
        s_valid <= 0;
        while (pending_words != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // mostly begin/end pairs with moderate durations, some noise
    task automatic random_events(input int n, input int secs);
        logic [3:0] sec;
        int pick;
        for (int i = 0; i < n; i++) begin
            sec = 4'($urandom_range(0, secs - 1));
            pick = $urandom_range(0, 99);
            clock_us = clock_us + $urandom_range(0, 400000);
            if (pick < 70) begin
                send_event(FN_BEGIN_SEC, sec, clock_us);
                clock_us = clock_us + ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000));
                send_event(FN_END_SEC, sec, clock_us);
                i++;
            end else if (pick < 80) begin
                send_event(FN_BEGIN_FRM, sec, clock_us);
                clock_us = clock_us + $urandom_range(0, 700000);
                send_event(FN_END_FRM, sec, clock_us);
                i++;
            end else if (pick < 97) begin
                send_event(3'($urandom_range(0, 4)), sec, $urandom_range(0, 1) ? clock_us : $urandom);
            end else if (pick < 99) begin
                send_event(3'($urandom_range(5, 7)), sec, clock_us);
            end else begin
                send_event(FN_CLR_ALL, sec, clock_us);
            end
        end
    endtask

    initial begin
        aresetn = 0; s_valid = 0; s_data = '0; m_ready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        clock_us = 0; sent_words = 0; big_stall = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // disabled: begin/end ignored, query still acts
        send_event(FN_BEGIN_SEC, 4'd0, 32'd5);
        send_event(FN_END_SEC, 4'd0, 32'd9);
        send_event(FN_BEGIN_FRM, 4'd1, 32'd0);
        send_event(FN_END_FRM, 4'd1, 32'd1);
        send_event(FN_QUERY, 4'd15, 32'hFFFF_FFFF);
        drain();
        reg_write(REG_ENABLED, 32'hFFFF_FFFF);
        reg_write(REG_WINDOW, 32'd1);
        send_event(FN_END_SEC, 4'd3, 32'd7);
        send_event(FN_BEGIN_SEC, 4'd15, 32'hFFFF_FFF0);
        send_event(FN_BEGIN_SEC, 4'd15, 32'hFFFF_FFFE);
        send_event(FN_END_SEC, 4'd15, 32'd4);
        send_event(FN_BEGIN_SEC, 4'd15, 32'd0);
        send_event(FN_END_SEC, 4'd15, 32'hFFFF_FFFF);
        send_event(3'd7, 4'd15, 32'd0);
        send_event(FN_END_FRM, 4'd0, 32'd2_000_000);
        send_event(FN_BEGIN_FRM, 4'd0, 32'd2_000_000);
        send_event(FN_END_FRM, 4'd0, 32'd2_000_001);
        send_event(FN_END_FRM, 4'd0, 32'd3_000_001);
        send_event(FN_CLR_SEC, 4'd15, 32'd0);
        send_event(FN_QUERY, 4'd15, 32'd0);
        send_event(FN_CLR_ALL, 4'd0, 32'hFFFF_FFFF);
        // fps interval that wraps through zero and ends exactly one second later
        send_event(FN_END_FRM, 4'd0, 32'd0);
        send_event(FN_END_FRM, 4'd0, 32'd999_999);
        drain();

        clock_us = 32'd10_000_000;
        reg_write(REG_WINDOW, 32'd64);
        random_events(250, 4);
        drain();
        reg_write(REG_WINDOW, 32'd127);
        random_events(200, 2);
        drain();
        reg_write(REG_WINDOW, 32'd0);
        random_events(150, 16);
        drain();
        reg_write(REG_WINDOW, 32'd3);
        big_stall = 1;
        random_events(200, 3);
        drain();
        reg_write(REG_ENABLED, 32'd0);
        random_events(50, 16);
        drain();
        reg_write(REG_ENABLED, 32'd1);
        reg_write(REG_WINDOW, 32'd60);
        random_events(180, 8);
        drain();

        $display("sent %0d events, checked %0d results", sent_words, checked_words);
        $display("window lengths 1, 3, 60, 64, 127 and 0; enabled and disabled");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off in the stall phase
    initial begin
        int r_gap;
        @(posedge aresetn);
        forever begin
            if (big_stall == 1) begin
                big_stall = 2;
                m_ready <= 0;
                repeat (3000) @(posedge aclk);
            end
            if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                r_gap = $urandom_range(0, 8);
                if (r_gap != 0) begin
                    m_ready <= 0;
                    repeat (r_gap) @(posedge aclk);
                end
                m_ready <= 1;
                do @(posedge aclk); while (!m_valid);
            end
        end
    end

endmodule

[sim.f]
src/swp_pkg.sv
src/swp_divider.sv
src/section_window_profiler.sv
tb/section_window_profiler_checker.sv
tb/section_window_profiler_tb.sv
